// ----- sv/ldmc_pkg.sv -----
// Shared types, constants and helpers for the LED dimmer mode controller.
package ldmc_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned SampleW = 10;
  localparam int unsigned DutyW   = 10;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned TickW   = 16;
  localparam int unsigned StepW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  // level arithmetic: duty plus or minus a step, with sign
  localparam int unsigned LevelW  = 12;

  localparam logic [DutyW-1:0] DutyMax        = 10'd1023;
  localparam logic [TickW-1:0] DebounceReset  = 16'd50;
  localparam logic [TickW-1:0] FadeReset      = 16'd10;
  localparam logic [StepW-1:0] StepReset      = 8'd4;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_PRESS  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_FLASH  = 2'd1,
    MODE_BREATH = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_FADE     = 2'd1,
    CFG_STEP     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [SampleW-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0] pwm_duty;
    logic [ModeW-1:0] mode_now;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

  // cyclic mode step; the unused code lands on blink as (3+1) mod 3 does
  function automatic mode_e next_mode(mode_e m);
    mode_e r;
    unique case (m)
      MODE_FOLLOW: r = MODE_FLASH;
      MODE_FLASH:  r = MODE_BREATH;
      MODE_BREATH: r = MODE_FOLLOW;
      default:     r = MODE_FLASH;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ldmc_if.sv -----
// Channel interfaces: input word, result word and configuration write.
interface ldmc_in_if;
  logic                            valid;
  logic                            ready;
  logic [ldmc_pkg::OpW-1:0]        operation;
  logic [ldmc_pkg::SampleW-1:0]    adc_sample;
  modport source (output valid, operation, adc_sample, input ready);
  modport sink   (input valid, operation, adc_sample, output ready);
endinterface

interface ldmc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ldmc_pkg::DutyW-1:0]    pwm_duty;
  logic [ldmc_pkg::ModeW-1:0]    mode_now;
  modport source (output valid, pwm_duty, mode_now, input ready);
  modport sink   (input valid, pwm_duty, mode_now, output ready);
endinterface

interface ldmc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ldmc_pkg::CfgIdxW-1:0]   index;
  logic [ldmc_pkg::CfgW-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ldmc_in_reg.sv -----
// Input register: holds one accepted word until the core takes it.
module ldmc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ldmc_pkg::in_item_t item_i,
  input  logic               free_i,
  output logic               valid_o,
  output ldmc_pkg::in_item_t item_o
);
  logic               valid_q, valid_d;
  ldmc_pkg::in_item_t item_q;
  logic               load;

  assign ready_o = !valid_q || free_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ----- sv/ldmc_core.sv -----
// Mode state, configuration registers and the per-word update of duty and mode.
module ldmc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ldmc_pkg::cfg_wr_t   cfg_i,
  input  logic                advance_i,
  input  ldmc_pkg::in_item_t  item_i,
  output ldmc_pkg::out_item_t res_o
);
  logic [ldmc_pkg::TickW-1:0]   debounce_q, fade_q;
  logic [ldmc_pkg::StepW-1:0]   step_q;

  logic [ldmc_pkg::SampleW-1:0] sample_q, sample_d;
  ldmc_pkg::mode_e              mode_q, mode_d;
  logic [ldmc_pkg::TickW-1:0]   tick_q, tick_d;
  logic [ldmc_pkg::TickW-1:0]   press_q, press_d;
  logic [ldmc_pkg::TickW-1:0]   blink_tick_q, blink_tick_d;
  logic                         blink_on_q, blink_on_d;
  logic [ldmc_pkg::TickW-1:0]   fade_tick_q, fade_tick_d;
  logic [ldmc_pkg::DutyW-1:0]   level_q, level_d;
  logic                         falling_q, falling_d;
  logic [ldmc_pkg::DutyW-1:0]   duty_q, duty_d;

  logic [ldmc_pkg::TickW-1:0]        tick_inc, blink_el, fade_el, press_el;
  logic [ldmc_pkg::DutyW-4:0]        blink_lim;
  logic                              blink_due, fade_due, press_ok;
  logic signed [ldmc_pkg::LevelW-1:0] lvl_base, lvl_step, lvl_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= ldmc_pkg::DebounceReset;
      fade_q     <= ldmc_pkg::FadeReset;
      step_q     <= ldmc_pkg::StepReset;
    end else if (cfg_i.valid) begin
      unique case (ldmc_pkg::cfg_idx_e'(cfg_i.index))
        ldmc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_i.data;
        ldmc_pkg::CFG_FADE:     fade_q     <= cfg_i.data;
        ldmc_pkg::CFG_STEP:     step_q     <= cfg_i.data[ldmc_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // elapsed times wrap at 16 bits
  assign tick_inc  = tick_q + 16'd1;
  assign blink_el  = tick_inc - blink_tick_q;
  assign fade_el   = tick_inc - fade_tick_q;
  assign press_el  = tick_q - press_q;
  // (1023 - sample) >> 3 is the inverted top seven bits
  assign blink_lim = ~sample_q[ldmc_pkg::SampleW-1:3];
  assign blink_due = blink_el > {9'd0, blink_lim};
  assign fade_due  = fade_el > fade_q;
  assign press_ok  = press_el >= debounce_q;

  assign lvl_base = $signed({2'b00, level_q});
  assign lvl_step = $signed({4'b0000, step_q});
  assign lvl_sum  = falling_q ? (lvl_base - lvl_step) : (lvl_base + lvl_step);

  always_comb begin
    sample_d     = sample_q;
    mode_d       = mode_q;
    tick_d       = tick_q;
    press_d      = press_q;
    blink_tick_d = blink_tick_q;
    blink_on_d   = blink_on_q;
    fade_tick_d  = fade_tick_q;
    level_d      = level_q;
    falling_d    = falling_q;
    duty_d       = duty_q;
    unique case (ldmc_pkg::op_e'(item_i.operation))
      ldmc_pkg::OP_TICK: begin
        tick_d = tick_inc;
        unique case (mode_q)
          ldmc_pkg::MODE_FOLLOW: duty_d = sample_q;
          ldmc_pkg::MODE_FLASH: begin
            if (blink_due) begin
              blink_tick_d = tick_inc;
              blink_on_d   = !blink_on_q;
              duty_d       = blink_on_q ? '0 : ldmc_pkg::DutyMax;
            end
          end
          ldmc_pkg::MODE_BREATH: begin
            if (fade_due) begin
              fade_tick_d = tick_inc;
              priority if (lvl_sum >= $signed({2'b00, ldmc_pkg::DutyMax})) begin
                level_d   = ldmc_pkg::DutyMax;
                falling_d = 1'b1;
              end else if (lvl_sum <= 0) begin
                level_d   = '0;
                falling_d = 1'b0;
              end else begin
                level_d   = lvl_sum[ldmc_pkg::DutyW-1:0];
              end
              duty_d = level_d;
            end
          end
          default: mode_d = ldmc_pkg::MODE_FOLLOW;
        endcase
      end
      ldmc_pkg::OP_PRESS: begin
        if (press_ok) begin
          mode_d = ldmc_pkg::next_mode(mode_q);
        end
        press_d = tick_q;
      end
      ldmc_pkg::OP_SAMPLE: sample_d = item_i.adc_sample;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q     <= '0;
      mode_q       <= ldmc_pkg::MODE_FOLLOW;
      tick_q       <= '0;
      press_q      <= '0;
      blink_tick_q <= '0;
      blink_on_q   <= 1'b0;
      fade_tick_q  <= '0;
      level_q      <= '0;
      falling_q    <= 1'b0;
      duty_q       <= '0;
    end else if (advance_i) begin
      sample_q     <= sample_d;
      mode_q       <= mode_d;
      tick_q       <= tick_d;
      press_q      <= press_d;
      blink_tick_q <= blink_tick_d;
      blink_on_q   <= blink_on_d;
      fade_tick_q  <= fade_tick_d;
      level_q      <= level_d;
      falling_q    <= falling_d;
      duty_q       <= duty_d;
    end
  end

  assign res_o.pwm_duty = duty_d;
  assign res_o.mode_now = mode_d;
endmodule

// ----- sv/ldmc_out_reg.sv -----
// Result register: holds a finished word until the sink takes it.
module ldmc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ldmc_pkg::out_item_t res_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ldmc_pkg::out_item_t item_o
);
  logic                valid_q, valid_d;
  ldmc_pkg::out_item_t item_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ----- sv/led_dimmer_mode_controller.sv -----
// Top level: LED dimmer mode controller.
// An accepted word waits in the input register; its result word is loaded
// into the result register. Throughput: one word per cycle while the sink
// takes results; the single update path between the two registers sets this.
// Reset (async, active low) clears all mode state and both stages and loads
// the configuration defaults; the configuration port is always ready.
module led_dimmer_mode_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  ldmc_in_if.sink    in_i,
  ldmc_out_if.source out_o,
  ldmc_cfg_if.sink   cfg_i
);
  ldmc_pkg::in_item_t  in_item, core_item;
  ldmc_pkg::out_item_t res, out_item;
  ldmc_pkg::cfg_wr_t   cfg_wr;
  logic                core_valid, out_free, advance;

  assign in_item.operation  = in_i.operation;
  assign in_item.adc_sample = in_i.adc_sample;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  assign advance = core_valid && out_free;

  ldmc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .free_i  (out_free),
    .valid_o (core_valid),
    .item_o  (core_item)
  );

  ldmc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .advance_i (advance),
    .item_i    (core_item),
    .res_o     (res)
  );

  ldmc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .item_o  (out_item)
  );

  assign out_o.pwm_duty = out_item.pwm_duty;
  assign out_o.mode_now = out_item.mode_now;
endmodule

// ----- sv/ldmc_checker.sv -----
// Port-level checks for the LED dimmer mode controller, bound to the top level.
module ldmc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ldmc_pkg::DutyW-1:0]   out_duty_i,
  input logic [ldmc_pkg::ModeW-1:0]   out_mode_i
);
  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_duty_i)
      && $stable(out_mode_i))
    else $error("result word changed while stalled");

  // input only stalls when the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without back pressure");

  // a result appearing on an empty output comes from a word taken through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word without matching input word");

  // the unused mode code never reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_mode_i <= ldmc_pkg::MODE_BREATH)
    else $error("unused mode code reported");
endmodule

bind led_dimmer_mode_controller ldmc_checker u_ldmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_duty_i  (out_o.pwm_duty),
  .out_mode_i  (out_o.mode_now)
);

// ----- tb/ldmc_checker.sv -----
// Checker for the LED dimmer: watches all three channels, predicts each result word and compares.
module ldmc_tb_checker
  import ldmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ldmc_in_if          in_i,
  ldmc_out_if         out_i,
  ldmc_cfg_if         cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [TickW-1:0]   debounce_q;
  logic [TickW-1:0]   fade_q;
  logic [StepW-1:0]   step_q;

  // controller state
  logic [SampleW-1:0] sample_q;
  mode_e              mode_q;
  logic [TickW-1:0]   tick_q;
  logic [TickW-1:0]   press_tick_q;
  logic [TickW-1:0]   blink_tick_q;
  logic               blink_on_q;
  logic [TickW-1:0]   fade_tick_q;
  logic [DutyW-1:0]   level_q;
  logic               falling_q;
  logic [DutyW-1:0]   duty_q;

  out_item_t          duty_mode_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatch_count_o++;
  endtask

  task automatic clear_state();
    debounce_q   = DebounceReset;
    fade_q       = FadeReset;
    step_q       = StepReset;
    sample_q     = '0;
    mode_q       = MODE_FOLLOW;
    tick_q       = '0;
    press_tick_q = '0;
    blink_tick_q = '0;
    blink_on_q   = 1'b0;
    fade_tick_q  = '0;
    level_q      = '0;
    falling_q    = 1'b0;
    duty_q       = '0;
    duty_mode_q.delete();
  endtask

  task automatic load_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    case (idx)
      CFG_DEBOUNCE: debounce_q = val;
      CFG_FADE:     fade_q     = val;
      CFG_STEP:     step_q     = val[StepW-1:0];
      default:      ;
    endcase
  endtask

  task automatic advance_tick();
    logic [TickW-1:0]   gap;
    logic [SampleW-1:0] blink_limit;
    int                 lvl;
    tick_q = tick_q + 1'b1;
    case (mode_q)
      MODE_FOLLOW: duty_q = sample_q;
      MODE_FLASH: begin
        gap         = tick_q - blink_tick_q;
        blink_limit = (DutyMax - sample_q) >> 3;
        if (gap > blink_limit) begin
          blink_tick_q = tick_q;
          blink_on_q   = ~blink_on_q;
          duty_q       = blink_on_q ? DutyMax : '0;
        end
      end
      MODE_BREATH: begin
        gap = tick_q - fade_tick_q;
        if (gap > fade_q) begin
          fade_tick_q = tick_q;
          lvl = int'(level_q);
          if (falling_q) lvl -= int'(step_q);
          else           lvl += int'(step_q);
          // clamp at the top first, then at zero as a signed value
          if (lvl >= int'(DutyMax)) begin
            lvl       = int'(DutyMax);
            falling_q = 1'b1;
          end else if (lvl <= 0) begin
            lvl       = 0;
            falling_q = 1'b0;
          end
          level_q = DutyW'(lvl);
          duty_q  = level_q;
        end
      end
      default: mode_q = MODE_FOLLOW;
    endcase
  endtask

  task automatic advance_press();
    logic [TickW-1:0] gap;
    gap = tick_q - press_tick_q;
    if (gap >= debounce_q) mode_q = mode_e'((int'(mode_q) + 1) % 3);
    press_tick_q = tick_q;
  endtask

  task automatic predict_word(input logic [OpW-1:0] op, input logic [SampleW-1:0] smp);
    out_item_t exp;
    case (op)
      OP_TICK:   advance_tick();
      OP_PRESS:  advance_press();
      OP_SAMPLE: sample_q = smp;
      default:   ;
    endcase
    exp.pwm_duty = duty_q;
    exp.mode_now = mode_q;
    duty_mode_q.push_back(exp);
  endtask

  task automatic compare_word();
    out_item_t exp;
    if (duty_mode_q.size() == 0) begin
      report_mismatch($sformatf("result word with none expected: duty %0d mode %0d",
                                out_i.pwm_duty, out_i.mode_now));
    end else begin
      exp = duty_mode_q.pop_front();
      if (out_i.pwm_duty !== exp.pwm_duty)
        report_mismatch($sformatf("pwm_duty %0d, expected %0d", out_i.pwm_duty, exp.pwm_duty));
      if (out_i.mode_now !== exp.mode_now)
        report_mismatch($sformatf("mode_now %0d, expected %0d", out_i.mode_now, exp.mode_now));
    end
  endtask

  // sampled at the edge: the stimulus side drives with nonblocking updates
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      mismatch_count_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) compare_word();
      if (cfg_i.valid && cfg_i.ready) load_register(cfg_i.index, cfg_i.data);
      if (in_i.valid && in_i.ready) predict_word(in_i.operation, in_i.adc_sample);
    end
    pending_o = duty_mode_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the LED dimmer testbench: clock, reset, stimulus phases and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ldmc_pkg::*;

  localparam int          ClkHalf       = 6;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxRunTicks   = 60;
  // operation and register codes the package leaves without a name
  localparam logic [OpW-1:0]     OpUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned idle_cycles;
  int unsigned words_sent;
  int unsigned cur_debounce;
  int unsigned mismatch_count;
  int unsigned pending;

  ldmc_in_if  word_in ();
  ldmc_out_if word_out ();
  ldmc_cfg_if cfg_wr ();

  led_dimmer_mode_controller i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_in),
    .out_o  (word_out),
    .cfg_i  (cfg_wr)
  );

  ldmc_tb_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (word_in),
    .out_i            (word_out),
    .cfg_i            (cfg_wr),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    word_out.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (word_in.valid && word_in.ready) || (word_out.valid && word_out.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk_i); while (!cfg_wr.ready);
  endtask

  task automatic send_word(input logic [OpW-1:0] op, input logic [SampleW-1:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      word_in.valid      <= 1'b0;
      word_in.operation  <= OpW'($urandom);
      word_in.adc_sample <= SampleW'($urandom);
      @(posedge clk_i);
    end
    word_in.valid      <= 1'b1;
    word_in.operation  <= op;
    word_in.adc_sample <= smp;
    do @(posedge clk_i); while (!word_in.ready);
    words_sent++;
  endtask

  // stop sending and wait until every result word has come back
  task automatic drain_words();
    word_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return DutyMax;
    if (r < 35) return '0;
    // high readings keep the blink period short
    if (r < 70) return SampleW'($urandom_range(1023, 896));
    return SampleW'($urandom);
  endfunction

  task automatic random_word();
    int unsigned r;
    int          run;
    r = $urandom_range(99);
    if (r < 10) begin
      // ticks straddling the debounce count (capped at MaxRunTicks), then a press
      run = int'(cur_debounce > MaxRunTicks ? MaxRunTicks : cur_debounce);
      run = run + int'($urandom_range(2)) - 1;
      repeat ((run < 0) ? 0 : run) send_word(OP_TICK, SampleW'($urandom));
      send_word(OP_PRESS, SampleW'($urandom));
    end else if (r < 58) begin
      send_word(OP_TICK, SampleW'($urandom));
    end else if (r < 73) begin
      send_word(OP_PRESS, SampleW'($urandom));
    end else if (r < 95) begin
      send_word(OP_SAMPLE, pick_sample());
    end else begin
      send_word(OpUnused, SampleW'($urandom));
    end
  endtask

  task automatic run_phase(input logic [CfgW-1:0] dbn, input logic [CfgW-1:0] fade,
                           input logic [CfgW-1:0] step_word, input int unsigned tx,
                           input int unsigned rx, input int unsigned n_words);
    int unsigned first;
    drain_words();
    write_reg(CfgUnused, CfgW'($urandom));
    write_reg(CFG_DEBOUNCE, dbn);
    write_reg(CFG_FADE, fade);
    write_reg(CFG_STEP, step_word);
    cfg_wr.valid <= 1'b0;
    cur_debounce = dbn;
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    first = words_sent;
    while (words_sent - first < n_words) random_word();
  endtask

  initial begin
    rst_ni              = 1'b0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    words_sent          = 0;
    cur_debounce        = DebounceReset;
    word_in.valid       <= 1'b0;
    word_in.operation   <= OP_TICK;
    word_in.adc_sample  <= '0;
    cfg_wr.valid        <= 1'b0;
    cfg_wr.index        <= CFG_DEBOUNCE;
    cfg_wr.data         <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: an early press falls inside the debounce window
    send_word(OP_SAMPLE, DutyMax);
    send_word(OP_TICK, '0);
    send_word(OP_PRESS, '0);
    drain_words();
    write_reg(CFG_DEBOUNCE, '0);
    write_reg(CFG_FADE, '0);
    write_reg(CFG_STEP, 16'd255);
    cfg_wr.valid <= 1'b0;
    cur_debounce = 0;

    // follow mode over zero and alternating-bit samples, unused operation
    send_word(OP_SAMPLE, '0);
    send_word(OP_TICK, '0);
    send_word(OP_SAMPLE, 10'h2AA);
    send_word(OP_TICK, '0);
    send_word(OP_SAMPLE, 10'h155);
    send_word(OpUnused, 10'h3FF);
    send_word(OP_TICK, '0);
    // blink with the shortest period
    send_word(OP_PRESS, '0);
    send_word(OP_SAMPLE, DutyMax);
    repeat (3) send_word(OP_TICK, '0);
    // breathing up into the top clamp and back down
    send_word(OP_PRESS, '0);
    repeat (6) send_word(OP_TICK, '0);
    send_word(OP_PRESS, '0);
    send_word(OP_TICK, '0);

    run_phase(16'd50,    16'd10,    16'd4,      0,  0,  80);
    run_phase(16'd2,     16'd1,     16'hAB07,   57, 0,  80);
    run_phase(16'd65535, 16'd65535, 16'd1,      0,  57, 80);
    // zero step: the level must hold still
    run_phase(16'd0,     16'd0,     16'd0,      9,  9,  80);
    run_phase(16'd3,     16'd2,     16'd255,    0,  0,  80);
    run_phase(16'd1,     16'd4,     16'd100,    0,  57, 80);

    drain_words();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- led_dimmer_mode_controller.f -----
sv/ldmc_pkg.sv
sv/ldmc_if.sv
sv/ldmc_in_reg.sv
sv/ldmc_core.sv
sv/ldmc_out_reg.sv
sv/led_dimmer_mode_controller.sv
sv/ldmc_checker.sv
tb/ldmc_checker.sv
tb/testbench.sv
